// ===== rtl/wpm_pkg.sv =====
// Shared constants and types of the wildcard pattern matcher.
`default_nettype none

package wpm_pkg;

    // Number of pattern positions, one cell each.
    localparam int MAX_LEN = 128;
    // Bits of a cell index and of a length that can reach MAX_LEN.
    localparam int IDX_W   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);

    // Wildcard bytes of a pattern.
    localparam logic [7:0] SYM_ANY  = 8'd63;
    localparam logic [7:0] SYM_STAR = 8'd42;

    // Kinds of input word.
    localparam logic OP_PATTERN = 1'b0;
    localparam logic OP_SUBJECT = 1'b1;

    // Controls broadcast from the top level to every cell.
    typedef struct packed {
        logic       step;     // a subject byte is accepted this cycle
        logic       fresh;    // reachable set is the star closure of position 0
        logic       load;     // a pattern byte is accepted this cycle
        logic       new_pat;  // that pattern byte opens a new pattern
        logic [7:0] sym;      // byte of the accepted word
    } t_bcast;

endpackage

`default_nettype wire

// ===== rtl/wpm_if.sv =====
// Valid/ready channels carrying input words and result words.
`default_nettype none

interface wpm_in_if;
    logic       valid;
    logic       ready;
    logic       opcode;
    logic [7:0] symbol;
    logic       last;

    modport source (output valid, output opcode, output symbol, output last, input ready);
    modport sink   (input valid, input opcode, input symbol, input last, output ready);
endinterface

interface wpm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic too_long;

    modport source (output valid, output matched, output too_long, input ready);
    modport sink   (input valid, input matched, input too_long, output ready);
endinterface

`default_nettype wire

// ===== rtl/wpm_cell.sv =====
// One pattern position: its byte, its reachable bit and its star-closure seed.
`default_nettype none

module wpm_cell
    import wpm_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_bcast i_bc,
    input  wire logic   i_wr,        // this cell takes the pattern byte
    input  wire logic   i_prev_wr,   // the left neighbor takes the pattern byte
    input  wire logic   i_lead,      // closure-of-0 bit handed over by the left neighbor
    input  wire logic   i_hit,       // the left neighbor makes this position reachable
    input  wire logic   i_next_act,  // the right neighbor holds a pattern byte
    output logic        o_lead,
    output logic        o_hit,
    output logic        o_act,
    output logic        o_term
);

    logic [7:0] r_sym;
    logic       r_act;
    logic       r_c0;
    logic       r_reach;
    logic       star;
    logic       eff_reach;
    logic       sym_ok;
    logic       n_reach;

    // Reachable bit as seen by this step, and the local match.
    assign star      = (r_sym == SYM_STAR);
    assign eff_reach = i_bc.fresh ? r_c0 : r_reach;
    assign sym_ok    = (r_sym == i_bc.sym) || (r_sym == SYM_ANY);

    // A star keeps its own position; the closure ripples on through runs of stars.
    assign n_reach = i_hit || (eff_reach && star && r_act);
    assign o_hit   = r_act && (star ? n_reach : (eff_reach && sym_ok));

    // The last occupied cell reports whether the pattern end is reached.
    assign o_term  = o_hit && !i_next_act;
    assign o_act   = r_act;

    // Closure bit of the position to the right, valid while this cell is written.
    assign o_lead  = r_c0 && (i_bc.sym == SYM_STAR);

    // Control state of the cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_c0  <= 1'b0;
        end else begin
            if (i_bc.load) begin
                r_act <= (r_act && !i_bc.new_pat) || i_wr;
            end
            if (i_prev_wr) begin
                r_c0 <= i_lead;
            end
        end
    end

    // Pattern byte and reachable bit.
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sym <= i_bc.sym;
        end
        if (i_bc.step) begin
            r_reach <= n_reach;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/wildcard_pattern_matcher.sv =====
// Top level of the wildcard pattern matcher: cell row, pattern loader and result register.
//
// Input words arrive on i_in (opcode, symbol, last). A pattern is loaded with
// opcode 0, one byte per word, the final byte flagged by last; '?' matches any
// one byte and '*' any run of bytes. Subject bytes follow with opcode 1, the
// final one flagged. On that final byte one result word appears on o_out:
// matched says whether the whole subject matches the whole pattern, too_long
// whether the pattern exceeded MAX_LEN bytes and was cut short.
// One cell per pattern position holds the byte and its reachable bit, and all
// cells update together; a run of stars passes the reachable bit along in the
// same cycle. A result is registered and shows in the cycle after its last
// subject byte is taken. A pattern byte that follows a finished pattern starts
// a new one and drops any subject in progress.
// Reset leaves an empty pattern, against which no subject matches, and needs
// no clearing pass. While a result waits and the receiver holds ready low,
// i_in.ready is low; once the receiver takes it, a new word is taken in the
// same cycle.
`default_nettype none

module wildcard_pattern_matcher
    import wpm_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    wpm_in_if.sink     i_in,
    wpm_out_if.source  o_out
);

    logic [LEN_W-1:0]   r_len;
    logic               r_ovf;
    logic               r_loading;
    logic               r_fresh;
    logic               r_out_valid;
    logic               r_matched;
    logic               r_too_long;

    logic               accept;
    logic               pat_acc;
    logic               sub_acc;
    logic               sub_last;
    logic               new_pat;
    logic [LEN_W-1:0]   base_len;
    logic               room;
    logic [IDX_W-1:0]   wr_idx;
    logic [LEN_W-1:0]   n_len;
    logic               n_ovf;
    t_bcast             bc;

    logic [MAX_LEN-1:0] wr_vec;
    logic [MAX_LEN-1:0] lead;
    logic [MAX_LEN:0]   hit;
    logic [MAX_LEN:0]   act_vec;
    logic [MAX_LEN-1:0] term;

    // Handshake: a word is taken unless a result waits on a stalled receiver.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign pat_acc    = accept && (i_in.opcode == OP_PATTERN);
    assign sub_acc    = accept && (i_in.opcode == OP_SUBJECT);
    assign sub_last   = sub_acc && i_in.last;

    // Pattern write position and length bookkeeping.
    assign new_pat  = pat_acc && !r_loading;
    assign base_len = new_pat ? '0 : r_len;
    assign room     = (base_len < LEN_W'(MAX_LEN));
    assign wr_idx   = base_len[IDX_W-1:0];
    assign n_len    = room ? (base_len + LEN_W'(1)) : base_len;
    assign n_ovf    = (r_ovf && !new_pat) || !room;

    // Controls shared by all cells.
    always_comb begin
        bc.step    = sub_acc;
        bc.fresh   = r_fresh;
        bc.load    = pat_acc;
        bc.new_pat = new_pat;
        bc.sym     = i_in.symbol;
    end

    assign hit[0]           = 1'b0;
    assign act_vec[MAX_LEN] = 1'b0;

    // Row of cells, one per pattern position.
    for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
        logic prev_wr;
        logic lead_in;

        assign wr_vec[j] = pat_acc && room && (wr_idx == IDX_W'(j));

        if (j == 0) begin : g_first
            // Position 0 is always in its own closure.
            assign prev_wr = 1'b1;
            assign lead_in = 1'b1;
        end else begin : g_rest
            assign prev_wr = wr_vec[j-1];
            assign lead_in = lead[j-1];
        end

        wpm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_bc       (bc),
            .i_wr       (wr_vec[j]),
            .i_prev_wr  (prev_wr),
            .i_lead     (lead_in),
            .i_hit      (hit[j]),
            .i_next_act (act_vec[j+1]),
            .o_lead     (lead[j]),
            .o_hit      (hit[j+1]),
            .o_act      (act_vec[j]),
            .o_term     (term[j])
        );
    end

    // Pattern and matching state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len     <= '0;
            r_ovf     <= 1'b0;
            r_loading <= 1'b1;
            r_fresh   <= 1'b1;
        end else if (pat_acc) begin
            r_len     <= n_len;
            r_ovf     <= n_ovf;
            r_loading <= !i_in.last;
            r_fresh   <= 1'b1;
        end else if (sub_acc) begin
            r_loading <= 1'b0;
            r_fresh   <= i_in.last;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sub_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sub_last) begin
            r_matched  <= |term;
            r_too_long <= r_ovf;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.matched  = r_matched;
    assign o_out.too_long = r_too_long;

    // The occupied cells always count up to the pattern length.
    a_act_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(act_vec) == int'(r_len))
        else $error("occupied cells disagree with pattern length");

    // Truncation is only flagged on a full pattern.
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_len == LEN_W'(MAX_LEN)))
        else $error("overflow flagged on a pattern that is not full");

    // A new result only follows a final subject byte.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(sub_last))
        else $error("result without a final subject byte");

    // An empty pattern never matches.
    a_empty_nomatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (sub_last && (r_len == '0)) |=> !r_matched)
        else $error("match reported against an empty pattern");

    // Input is held off only by a waiting, stalled result.
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready && !sub_acc))
        else $error("input held off without a stalled result");

endmodule

`default_nettype wire
